// File: src/psps_pkg.sv
package psps_pkg;

   // table geometry
   localparam int MAX_PATHS = 256;
   localparam int PATH_W    = $clog2(MAX_PATHS);
   localparam int CNT_W     = PATH_W + 1;
   localparam int PEN_W     = 8;
   localparam int ENT_W     = 16;
   localparam int BITS_W    = 4;

   // penalties added by feedback
   localparam logic [PEN_W-1:0] PEN_ECN  = PEN_W'(1);
   localparam logic [PEN_W-1:0] PEN_NACK = PEN_W'(4);

   // feedback codes
   localparam logic [1:0] FB_GOOD    = 2'd0;
   localparam logic [1:0] FB_ECN     = 2'd1;
   localparam logic [1:0] FB_NACK    = 2'd2;
   localparam logic [1:0] FB_TIMEOUT = 2'd3;

   // request kinds
   localparam logic KIND_FEEDBACK = 1'b0;
   localparam logic KIND_REQUEST  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_PATH_BITS     = 2'd0;
   localparam logic [1:0] REG_MAX_PENALTY   = 2'd1;
   localparam logic [1:0] REG_ENTROPY_UPPER = 2'd2;

   // microcode steps
   typedef enum logic [2:0] {
      ST_FB_RD  = 3'd0,
      ST_FB_WR  = 3'd1,
      ST_RQ_RD  = 3'd2,
      ST_RQ_EV  = 3'd3,
      ST_RQ_CHK = 3'd4,
      ST_RQ_ADV = 3'd5,
      ST_RQ_FIN = 3'd6
   } step_type;

   // jump conditions
   typedef enum logic [1:0] {
      J_NONE = 2'd0,
      J_ZERO = 2'd1,
      J_OVER = 2'd2
   } jcond_type;

   // one control word
   typedef struct packed {
      logic      mem_rd;
      logic      addr_fb;
      logic      wr_fb;
      logic      wr_dec;
      logic      step_inc;
      logic      adv;
      logic      out_load;
      logic      done;
      jcond_type jcond;
      step_type  nxt;
      step_type  alt;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic val_zero;
      logic steps_over;
      logic out_busy;
   } stat_type;

   // configuration as the datapath uses it
   typedef struct packed {
      logic [PATH_W-1:0] mask;
      logic [CNT_W-1:0]  n;
      logic [PEN_W-1:0]  max_pen;
      logic [ENT_W-1:0]  upper;
   } cfg_type;

   // microcode program
   function automatic ucode_type ucode_rom(step_type st);
      ucode_type w;
      w = '0;
      w.jcond = J_NONE;
      w.nxt   = ST_FB_RD;
      w.alt   = ST_FB_RD;
      case (st)
         ST_FB_RD: begin
            w.mem_rd  = 1'b1;
            w.addr_fb = 1'b1;
            w.nxt     = ST_FB_WR;
         end
         ST_FB_WR: begin
            w.addr_fb = 1'b1;
            w.wr_fb   = 1'b1;
            w.done    = 1'b1;
         end
         ST_RQ_RD: begin
            w.mem_rd = 1'b1;
            w.nxt    = ST_RQ_EV;
         end
         ST_RQ_EV: begin
            w.wr_dec   = 1'b1;
            w.step_inc = 1'b1;
            w.jcond    = J_ZERO;
            w.alt      = ST_RQ_FIN;
            w.nxt      = ST_RQ_CHK;
         end
         ST_RQ_CHK: begin
            w.jcond = J_OVER;
            w.alt   = ST_RQ_FIN;
            w.nxt   = ST_RQ_ADV;
         end
         ST_RQ_ADV: begin
            w.adv = 1'b1;
            w.nxt = ST_RQ_RD;
         end
         ST_RQ_FIN: begin
            w.adv      = 1'b1;
            w.out_load = 1'b1;
            w.done     = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// File: src/psps_if.sv
interface psps_req_if;
   import psps_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ENT_W-1:0]  path_id;
   logic [1:0]        feedback;
   logic [ENT_W-1:0]  rand_first;
   logic [ENT_W-1:0]  rand_second;
   modport source (output valid, kind, path_id, feedback, rand_first, rand_second,
                   input ready);
   modport sink   (input valid, kind, path_id, feedback, rand_first, rand_second,
                   output ready);
endinterface

interface psps_rsp_if;
   import psps_pkg::*;
   logic              valid;
   logic              ready;
   logic [ENT_W-1:0]  entropy;
   logic [CNT_W-1:0]  penalised_paths;
   modport source (output valid, entropy, penalised_paths, input ready);
   modport sink   (input valid, entropy, penalised_paths, output ready);
endinterface

interface psps_csr_if;
   import psps_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        index;
   logic [ENT_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/psps_seq.sv
module psps_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  start_kind,
   input  psps_pkg::stat_type    stat,
   output psps_pkg::ucode_type   ctrl,
   output logic                  busy
);
   import psps_pkg::*;

   logic      busy_ff, busy_in;
   step_type  upc_ff, upc_in;
   ucode_type word;
   logic      go;
   logic      take_alt;

   // control word of the current step
   assign word = ucode_rom(upc_ff);
   assign go   = busy_ff && !(word.out_load && stat.out_busy);
   assign busy = busy_ff;

   // actions only fire on a step that proceeds
   always_comb begin
      ctrl = '0;
      if (go) begin
         ctrl = word;
      end
   end

   // next step
   always_comb begin
      busy_in  = busy_ff;
      upc_in   = upc_ff;
      take_alt = 1'b0;
      case (word.jcond)
         J_ZERO:  take_alt = stat.val_zero;
         J_OVER:  take_alt = stat.steps_over;
         default: take_alt = 1'b0;
      endcase
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            upc_in  = (start_kind == KIND_REQUEST) ? ST_RQ_RD : ST_FB_RD;
         end
      end else if (go) begin
         if (word.done) begin
            busy_in = 1'b0;
         end else begin
            upc_in = take_alt ? word.alt : word.nxt;
         end
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= ST_FB_RD;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

endmodule

// File: src/psps_datapath.sv
module psps_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [psps_pkg::ENT_W-1:0]    in_path_id,
   input  logic [1:0]                    in_feedback,
   input  logic [psps_pkg::ENT_W-1:0]    in_rand_first,
   input  logic [psps_pkg::ENT_W-1:0]    in_rand_second,
   input  psps_pkg::cfg_type             cfg,
   input  psps_pkg::ucode_type           ctrl,
   output psps_pkg::stat_type            stat,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [psps_pkg::ENT_W-1:0]    out_entropy,
   output logic [psps_pkg::CNT_W-1:0]    out_count
);
   import psps_pkg::*;

   // penalty memory and its valid bits
   logic [PEN_W-1:0]     mem [MAX_PATHS];
   logic [MAX_PATHS-1:0] valid_ff;
   logic [PEN_W-1:0]     rd_data_ff;
   logic                 rd_valid_ff;

   // request state
   logic [PATH_W-1:0] pidx_ff;
   logic [1:0]        fb_ff;
   logic [PATH_W-1:0] r1_ff, r2_ff;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic              dec_done_ff, dec_done_in;
   logic              wrapped_ff, wrapped_in;

   // persistent state
   logic [CNT_W-1:0]  ri_ff, ri_in;
   logic [PATH_W-1:0] rx_ff, rx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [ENT_W-1:0]  ent_ff;
   logic [CNT_W-1:0]  ocnt_ff;

   logic [PATH_W-1:0] e;
   logic [PATH_W-1:0] addr;
   logic [PEN_W-1:0]  old_val;
   logic [PEN_W-1:0]  add_val;
   logic [PEN_W:0]    sum;
   logic [PEN_W-1:0]  fb_val;
   logic              we;
   logic [PEN_W-1:0]  wd;
   logic [CNT_W-1:0]  ri_inc;

   // current walk position
   assign e       = (ri_ff[PATH_W-1:0] ^ rx_ff) & cfg.mask;
   assign addr    = ctrl.addr_fb ? pidx_ff : e;
   assign old_val = rd_valid_ff ? rd_data_ff : '0;

   // feedback penalty with saturation
   always_comb begin
      case (fb_ff)
         FB_ECN:     add_val = PEN_ECN;
         FB_NACK:    add_val = PEN_NACK;
         FB_TIMEOUT: add_val = cfg.max_pen;
         default:    add_val = '0;
      endcase
      sum    = {1'b0, old_val} + {1'b0, add_val};
      fb_val = (sum > {1'b0, cfg.max_pen}) ? cfg.max_pen : sum[PEN_W-1:0];
   end

   // write select
   always_comb begin
      we = 1'b0;
      wd = fb_val;
      if (ctrl.wr_fb) begin
         we = 1'b1;
      end else if (ctrl.wr_dec && (old_val != '0) && !dec_done_ff) begin
         we = 1'b1;
         wd = old_val - PEN_W'(1);
      end
   end

   // penalty memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wd;
      end
      if (ctrl.mem_rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[addr] <= 1'b1;
         end
         if (ctrl.mem_rd) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   // penalised path count follows zero and nonzero transitions
   always_comb begin
      cnt_in = cnt_ff;
      if (we) begin
         if ((old_val == '0) && (wd != '0)) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else if ((old_val != '0) && (wd == '0) && (cnt_ff != '0)) begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   // walk bookkeeping and round advance
   assign ri_inc = ri_ff + CNT_W'(1);

   always_comb begin
      steps_in    = steps_ff;
      dec_done_in = dec_done_ff;
      wrapped_in  = wrapped_ff;
      ri_in       = ri_ff;
      rx_in       = rx_ff;
      if (start) begin
         steps_in    = '0;
         dec_done_in = 1'b0;
         wrapped_in  = 1'b0;
      end else begin
         if (ctrl.step_inc && (old_val != '0)) begin
            steps_in = steps_ff + CNT_W'(1);
         end
         if (ctrl.wr_dec && (old_val != '0)) begin
            dec_done_in = 1'b1;
         end
         if (ctrl.adv) begin
            if (ri_inc >= cfg.n) begin
               ri_in      = '0;
               rx_in      = (wrapped_ff ? r2_ff : r1_ff) & cfg.mask;
               wrapped_in = 1'b1;
            end else begin
               ri_in = ri_inc;
            end
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (ctrl.out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff        <= '0;
         rx_ff        <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         steps_ff     <= '0;
         dec_done_ff  <= 1'b0;
         wrapped_ff   <= 1'b0;
      end else begin
         ri_ff        <= ri_in;
         rx_ff        <= rx_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         steps_ff     <= steps_in;
         dec_done_ff  <= dec_done_in;
         wrapped_ff   <= wrapped_in;
      end
   end

   // request fields and result payload
   always_ff @(posedge clock) begin
      if (start) begin
         pidx_ff <= in_path_id[PATH_W-1:0] & cfg.mask;
         fb_ff   <= in_feedback;
         r1_ff   <= in_rand_first[PATH_W-1:0];
         r2_ff   <= in_rand_second[PATH_W-1:0];
      end
      if (ctrl.out_load) begin
         ent_ff  <= {cfg.upper[ENT_W-1:PATH_W], (cfg.upper[PATH_W-1:0] & ~cfg.mask) | e};
         ocnt_ff <= cnt_ff;
      end
   end

   assign stat.val_zero   = (old_val == '0);
   assign stat.steps_over = (steps_ff > cfg.n);
   assign stat.out_busy   = out_valid_ff && !out_ready;

   assign out_valid   = out_valid_ff;
   assign out_entropy = ent_ff;
   assign out_count   = ocnt_ff;

endmodule

// File: src/penalty_skip_path_selector.sv
// feedback request: a read step, then a write step, before the next request is accepted
// entropy request: read, evaluate and finish steps when the first path met is clear,
// plus read, evaluate, check and advance steps per penalised path skipped;
// a held result stalls the last step, and all steps share the single penalty memory port
// result appears in an output register the cycle after the final step
// synchronous reset clears the penalty table at once via per-entry valid bits
module penalty_skip_path_selector (
   input logic        clock,
   input logic        reset,
   psps_req_if.sink   req_if,
   psps_rsp_if.source rsp_if,
   psps_csr_if.sink   csr_if
);
   import psps_pkg::*;

   logic [BITS_W-1:0] path_bits_ff;
   logic [PEN_W-1:0]  max_pen_ff;
   logic [ENT_W-1:0]  upper_ff;
   logic [BITS_W-1:0] eff_bits;
   cfg_type           cfg;
   ucode_type         ctrl;
   stat_type          stat;
   logic              busy;
   logic              start;

   // configuration registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         path_bits_ff <= BITS_W'(8);
         max_pen_ff   <= PEN_W'(15);
         upper_ff     <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_PATH_BITS:     path_bits_ff <= csr_if.data[BITS_W-1:0];
            REG_MAX_PENALTY:   max_pen_ff   <= csr_if.data[PEN_W-1:0];
            REG_ENTROPY_UPPER: upper_ff     <= csr_if.data;
            default: ;
         endcase
      end
   end

   // path count limited to the table size
   assign eff_bits    = (path_bits_ff > BITS_W'(PATH_W)) ? BITS_W'(PATH_W) : path_bits_ff;
   assign cfg.n       = CNT_W'(1) << eff_bits;
   assign cfg.mask    = PATH_W'(cfg.n - CNT_W'(1));
   assign cfg.max_pen = max_pen_ff;
   assign cfg.upper   = upper_ff;

   // request intake
   assign req_if.ready = !busy;
   assign start        = req_if.valid && !busy;

   psps_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_kind (req_if.kind),
      .stat       (stat),
      .ctrl       (ctrl),
      .busy       (busy)
   );

   psps_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .in_path_id     (req_if.path_id),
      .in_feedback    (req_if.feedback),
      .in_rand_first  (req_if.rand_first),
      .in_rand_second (req_if.rand_second),
      .cfg            (cfg),
      .ctrl           (ctrl),
      .stat           (stat),
      .out_valid      (rsp_if.valid),
      .out_ready      (rsp_if.ready),
      .out_entropy    (rsp_if.entropy),
      .out_count      (rsp_if.penalised_paths)
   );

endmodule
